// ----- src/ultrasonic_echo_ranger_unit_defines.svh -----
// Assertion macros shared by the echo ranger RTL.
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define UER_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("echo ranger: same-cycle check failed");
// Next-cycle implication.
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("echo ranger: next-cycle check failed");
`else
`define UER_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/uer_pkg.sv -----
package uer_pkg;

	// Timer width default
	localparam int TIMER_BITS_DEF = 16;

	// trigger_length register
	localparam logic [15:0] TRIG_LEN_RESET = 16'd10;
	localparam int          PADDR_W        = 3;
	localparam logic [0:0]  REG_TRIG_LEN   = 1'b0;

	// Front-to-back queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// ticks / 116 == (ticks >> 2) / 29, done as a reciprocal multiply
	localparam int            CM_X_W   = 14;
	localparam int            CM_M_W   = 15;
	localparam logic [14:0]   CM_MULT  = 15'd18079;
	localparam int            CM_SHIFT = 19;
	localparam int            CM_PROD_W = CM_X_W + CM_M_W;

	// Measurement phases
	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_TRIG = 4'b0010,
		PH_RISE = 4'b0100,
		PH_FALL = 4'b1000
	} phase_t;

	// One tick request
	typedef struct packed {
		logic start_req;
		logic echo_level;
	} in_t;

	// One tick result
	typedef struct packed {
		logic        trigger_out;
		logic        busy_res;
		logic        done_res;
		logic [15:0] width_ticks;
		logic [14:0] width_us;
		logic [9:0]  width_cm;
		logic [15:0] overflow_count;
	} out_t;

	// Classified tick, front to back
	typedef struct packed {
		logic        trig;
		logic        busy;
		logic        done;
		logic [15:0] width;
		logic [15:0] wraps;
	} raw_t;

endpackage

// ----- src/uer_front.sv -----
`include "ultrasonic_echo_ranger_unit_defines.svh"

module uer_front import uer_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] trig_len,
	input  in_t         req,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        q_full,
	output logic        push,
	output raw_t        push_data
);

	localparam int                    CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [TIMER_BITS-1:0] TMAX  = '1;

	phase_t                phase_q, phase_d;
	logic [TIMER_BITS-1:0] timer_q, trig_start_q, trig_start_d, echo_start_q, echo_start_d;
	logic [TIMER_BITS-1:0] elapsed;
	logic [TIMER_BITS-1:0] pulse_len;
	logic [CMP_W-1:0]      len_ext, max_ext, len_sat;
	logic                  last_echo_q;
	logic [15:0]           wrap_q, wrap_d, width_q, width_d;
	logic                  trig, done;

	assign req_ready = !q_full;
	assign push      = req_valid && !q_full;

	// Trigger length saturated to the timer range
	assign len_ext = CMP_W'(trig_len);
	assign max_ext = CMP_W'(TMAX);
	assign len_sat = (len_ext > max_ext) ? max_ext : len_ext;
	assign elapsed = timer_q - trig_start_q;

	// Pulse width wraps at the timer width
	assign pulse_len = timer_q - echo_start_q;

	// Phase sequencing for the current tick
	always_comb begin
		phase_d      = phase_q;
		trig         = 1'b0;
		done         = 1'b0;
		trig_start_d = trig_start_q;
		echo_start_d = echo_start_q;
		width_d      = width_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (req.start_req) begin
					trig_start_d = timer_q;
					trig         = 1'b1;
					phase_d      = PH_TRIG;
				end
			end
			PH_TRIG: begin
				if (CMP_W'(elapsed) >= len_sat) begin
					phase_d = PH_RISE;
				end else begin
					trig = 1'b1;
				end
			end
			PH_RISE: begin
				if (!last_echo_q && req.echo_level) begin
					echo_start_d = timer_q;
					phase_d      = PH_FALL;
				end
			end
			PH_FALL: begin
				if (last_echo_q && !req.echo_level) begin
					width_d = 16'(pulse_len);
					done    = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// Wrap counter after this tick
	assign wrap_d = (timer_q == TMAX) ? wrap_q + 16'd1 : wrap_q;

	always_comb begin
		push_data.trig  = trig;
		push_data.busy  = (phase_d != PH_IDLE);
		push_data.done  = done;
		push_data.width = width_d;
		push_data.wraps = wrap_d;
	end

	// State advances once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			timer_q      <= '0;
			trig_start_q <= '0;
			echo_start_q <= '0;
			last_echo_q  <= 1'b0;
			wrap_q       <= '0;
			width_q      <= '0;
		end else if (push) begin
			phase_q      <= phase_d;
			timer_q      <= timer_q + TIMER_BITS'(1);
			trig_start_q <= trig_start_d;
			echo_start_q <= echo_start_d;
			last_echo_q  <= req.echo_level;
			wrap_q       <= wrap_d;
			width_q      <= width_d;
		end
	end

	`UER_ASSERT_NEXT(a_done_to_idle, clk, arst_n, push && push_data.done, phase_q == PH_IDLE)
	`UER_ASSERT_IMPL(a_trig_phase, clk, arst_n, push && push_data.trig, phase_q == PH_IDLE || phase_q == PH_TRIG)
	`UER_ASSERT_NEXT(a_busy_phase, clk, arst_n, push && push_data.busy, phase_q != PH_IDLE)

endmodule

// ----- src/uer_queue.sv -----
`include "ultrasonic_echo_ranger_unit_defines.svh"

module uer_queue import uer_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  raw_t push_data,
	input  logic pop,
	output raw_t head,
	output logic full,
	output logic empty
);

	raw_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`UER_ASSERT_IMPL(a_no_overflow, clk, arst_n, push, count_q != QCNT_W'(QUEUE_DEPTH))
	`UER_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, count_q != '0)

endmodule

// ----- src/uer_back.sv -----
module uer_back import uer_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  raw_t head,
	input  logic empty,
	output logic pop,
	output out_t rsp,
	output logic rsp_valid,
	input  logic rsp_ready
);

	raw_t                 res_s1;
	logic [CM_PROD_W-1:0] prod, prod_s1;
	logic                 valid_s1;

	// Output register refills when empty or being drained
	assign pop  = !empty && (!valid_s1 || rsp_ready);
	assign prod = CM_PROD_W'(head.width[15:2]) * CM_PROD_W'(CM_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_s1  <= head;
			prod_s1 <= prod;
		end
	end

	// Result formatting
	assign rsp_valid = valid_s1;
	always_comb begin
		rsp.trigger_out    = res_s1.trig;
		rsp.busy_res       = res_s1.busy;
		rsp.done_res       = res_s1.done;
		rsp.width_ticks    = res_s1.width;
		rsp.width_us       = res_s1.width[15:1];
		rsp.width_cm       = prod_s1[CM_SHIFT+9:CM_SHIFT];
		rsp.overflow_count = res_s1.wraps;
	end

endmodule

// ----- src/ultrasonic_echo_ranger_unit.sv -----
// A result is registered first in a queue entry and then in the output register
// before it leaves as valid.
// Throughput: one request per cycle, sustained, with rsp_ready held high.
// The front state machine finishes each tick in the cycle it is accepted;
// a two-entry queue and the output register decouple it from the back end.
// Reset (arst_n low): phase idle, timer, captures, wrap count and width cleared,
// queue and output emptied, trigger_length set to 10.
module ultrasonic_echo_ranger_unit import uer_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  in_t                req,
	input  logic               req_valid,
	output logic               req_ready,
	output out_t               rsp,
	output logic               rsp_valid,
	input  logic               rsp_ready
);

	logic [15:0] trig_len_q;
	logic        q_push, q_pop, q_full, q_empty;
	raw_t        q_in, q_head;

	// Configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_len_q <= TRIG_LEN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_TRIG_LEN) begin
			trig_len_q <= pwdata[15:0];
		end
	end
	assign prdata = (paddr[2] == REG_TRIG_LEN) ? {16'd0, trig_len_q} : 32'd0;

	uer_front #(
		.TIMER_BITS(TIMER_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.trig_len  (trig_len_q),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_in)
	);

	uer_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	uer_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule
